// File: sv/distinct_color_counter_core_defines.svh
// Assertion macros shared by the distinct color counter RTL.
// Used by files that include this header; depends on nothing else.
`ifndef DISTINCT_COLOR_COUNTER_CORE_DEFINES_SVH
`define DISTINCT_COLOR_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dcc_pkg.sv
`timescale 1ns / 1ps
// Shared constants and the token type of the distinct color counter.
// Has no dependencies; used by dcc_cell and distinct_color_counter_core.
package dcc_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int CHAN_W        = 8;
  localparam int COLOR_W       = 3 * CHAN_W;
  localparam int SLOT_W        = 8;
  localparam int COUNT_OUT_W   = 9;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef struct packed {
    logic   vld;
    color_t color;
    cnt_t   count;
    logic   found;
    logic   is_new;
    idx_t   slot;
  } tok_t;

endpackage

// File: sv/dcc_cell.sv
`timescale 1ns / 1ps
// One table cell: stores a color and checks the passing token against it.
// Depends on dcc_pkg for the token type and widths.
module dcc_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  dcc_pkg::idx_t cell_idx,
  input  dcc_pkg::tok_t tok_i,
  output dcc_pkg::tok_t tok_o
);
  import dcc_pkg::*;

  color_t color_r;
  tok_t   tok_r;
  tok_t   tok_nxt;
  logic   live;
  logic   hit;
  logic   wr;

  always_comb begin
    live    = tok_i.vld && !tok_i.found;
    hit     = live && (CNT_W'(cell_idx) < tok_i.count) && (color_r == tok_i.color);
    wr      = live && (CNT_W'(cell_idx) == tok_i.count);
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.slot  = cell_idx;
    end else if (wr) begin
      tok_nxt.found  = 1'b1;
      tok_nxt.is_new = 1'b1;
      tok_nxt.slot   = cell_idx;
      tok_nxt.count  = tok_i.count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr) begin
      color_r <= tok_i.color;
    end
  end

  assign tok_o = tok_r;

endmodule

// File: sv/distinct_color_counter_core.sv
`timescale 1ns / 1ps
// Distinct color counter: top level with the entry register, the cell chain
// and the result register. Depends on dcc_pkg, dcc_cell and the defines header.
//
// Usage: each input item is one pixel (red, green, blue) plus a start flag
// that empties the color table before the pixel is handled. Each item gives
// exactly one result: is_new, the slot holding the color, the count of
// distinct colors after this pixel, and overflow when a new color did not
// fit in a full table. A full table keeps its count at TABLE_ENTRIES.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low.
// An accepted item is registered in the entry register, then walks the cell
// chain one cell per cycle while the chain advances, and then is registered in
// the result register. One item is in the cell chain at a time, so a new item
// is accepted only after the previous one has left the chain.
// A new item may be accepted while the previous result still waits.
// If the receiver stalls, the result register holds and the chain freezes
// once its token reaches the end. Reset empties the table and the pipeline.
`include "distinct_color_counter_core_defines.svh"
module distinct_color_counter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_start_of_image,
  input  logic [dcc_pkg::CHAN_W-1:0]      in_red,
  input  logic [dcc_pkg::CHAN_W-1:0]      in_green,
  input  logic [dcc_pkg::CHAN_W-1:0]      in_blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_is_new,
  output logic [dcc_pkg::SLOT_W-1:0]      out_slot,
  output logic [dcc_pkg::COUNT_OUT_W-1:0] out_distinct_count,
  output logic                            out_overflow
);
  import dcc_pkg::*;

  tok_t                   chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES:0] tok_vld;
  tok_t                   ent_r, ent_nxt;
  tok_t                   tail;
  cnt_t                   count_r, count_nxt;
  logic                   busy_r, busy_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   res_is_new_r, res_is_new_nxt;
  logic [SLOT_W-1:0]      res_slot_r, res_slot_nxt;
  logic [COUNT_OUT_W-1:0] res_count_r, res_count_nxt;
  logic                   res_ovf_r, res_ovf_nxt;
  logic                   adv;
  logic                   take_in;
  logic                   take_tail;

  assign chain[0] = ent_r;
  assign tail     = chain[TABLE_ENTRIES];

  for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
    dcc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (IDX_W'(gi)),
      .tok_i    (chain[gi]),
      .tok_o    (chain[gi+1])
    );
  end

  for (genvar gv = 0; gv <= TABLE_ENTRIES; gv++) begin : g_vld
    assign tok_vld[gv] = chain[gv].vld;
  end

  assign in_stall  = busy_r;
  assign take_in   = in_valid && !busy_r;
  assign adv       = !(tail.vld && out_valid_r && out_stall);
  assign take_tail = tail.vld && adv;

  always_comb begin
    ent_nxt   = ent_r;
    busy_nxt  = busy_r;
    count_nxt = count_r;
    if (take_in) begin
      ent_nxt       = '0;
      ent_nxt.vld   = 1'b1;
      ent_nxt.color = {in_red, in_green, in_blue};
      ent_nxt.count = in_start_of_image ? '0 : count_r;
      busy_nxt      = 1'b1;
    end else if (adv) begin
      ent_nxt.vld = 1'b0;
    end
    if (take_tail) begin
      busy_nxt  = 1'b0;
      count_nxt = tail.count;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    res_is_new_nxt = res_is_new_r;
    res_slot_nxt   = res_slot_r;
    res_count_nxt  = res_count_r;
    res_ovf_nxt    = res_ovf_r;
    if (take_tail) begin
      out_valid_nxt  = 1'b1;
      res_is_new_nxt = tail.is_new || !tail.found;
      res_ovf_nxt    = !tail.found;
      res_slot_nxt   = tail.found ? SLOT_W'(tail.slot) : '0;
      res_count_nxt  = COUNT_OUT_W'(tail.count);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r       <= '0;
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ent_r       <= ent_nxt;
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_is_new_r <= res_is_new_nxt;
    res_slot_r   <= res_slot_nxt;
    res_count_r  <= res_count_nxt;
    res_ovf_r    <= res_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_is_new         = res_is_new_r;
  assign out_slot           = res_slot_r;
  assign out_distinct_count = res_count_r;
  assign out_overflow       = res_ovf_r;

  `DCC_ASSERT_IMP(a_one_token, 1'b1, $countones(tok_vld) <= 1, "More than one item in the chain")
  `DCC_ASSERT_IMP(a_busy_match, 1'b1, busy_r == (|tok_vld), "Busy flag disagrees with the chain")
  `DCC_ASSERT_IMP(a_count_max, 1'b1, count_r <= CNT_W'(TABLE_ENTRIES), "Entry count above table size")
  `DCC_ASSERT_IMP(a_ovf_full, out_valid_r && res_ovf_r,
    res_count_r == COUNT_OUT_W'(TABLE_ENTRIES) && res_is_new_r, "Overflow without a full table")
  `DCC_ASSERT_NEXT(a_freeze, tail.vld && out_valid_r && out_stall,
    $stable(tail) && $stable(res_slot_r), "Chain moved while the result was stalled")

endmodule

// File: bench/color_count_checker.sv
`timescale 1ns / 1ps
// Checker for the distinct color counter: keeps its own color table from the
// accepted pixels and compares every result item. Depends on dcc_pkg only.
module color_count_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_start_of_image,
  input  logic [dcc_pkg::CHAN_W-1:0]      in_red,
  input  logic [dcc_pkg::CHAN_W-1:0]      in_green,
  input  logic [dcc_pkg::CHAN_W-1:0]      in_blue,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_is_new,
  input  logic [dcc_pkg::SLOT_W-1:0]      out_slot,
  input  logic [dcc_pkg::COUNT_OUT_W-1:0] out_distinct_count,
  input  logic                            out_overflow,
  output int                              error_count,
  output int                              pending_count,
  output int                              checked_count,
  output int                              overflow_count,
  output int                              repeat_count
);

  typedef struct packed {
    logic                            is_new;
    logic [dcc_pkg::SLOT_W-1:0]      slot;
    logic [dcc_pkg::COUNT_OUT_W-1:0] count;
    logic                            overflow;
  } tally_t;

  dcc_pkg::color_t stored_colors [dcc_pkg::TABLE_ENTRIES];
  int              stored_count;
  tally_t          predicted_tallies [$];
  tally_t          want;
  int              mismatches;
  int              checked;
  int              overflows;
  int              repeats;

  function automatic tally_t classify_pixel(input logic sof, input dcc_pkg::color_t color);
    tally_t t;
    int     hit;
    hit = -1;
    if (sof) begin
      stored_count = 0;
    end
    for (int i = 0; i < stored_count; i++) begin
      if (hit < 0 && stored_colors[i] == color) begin
        hit = i;
      end
    end
    t.overflow = 1'b0;
    if (hit >= 0) begin
      t.is_new = 1'b0;
      t.slot   = hit[dcc_pkg::SLOT_W-1:0];
    end else if (stored_count < dcc_pkg::TABLE_ENTRIES) begin
      stored_colors[stored_count] = color;
      t.is_new = 1'b1;
      t.slot   = stored_count[dcc_pkg::SLOT_W-1:0];
      stored_count++;
    end else begin
      t.is_new   = 1'b1;
      t.overflow = 1'b1;
      t.slot     = '0;
    end
    t.count = stored_count[dcc_pkg::COUNT_OUT_W-1:0];
    return t;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      stored_count = 0;
      predicted_tallies.delete();
      mismatches = 0;
      checked    = 0;
      overflows  = 0;
      repeats    = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_tallies.push_back(classify_pixel(in_start_of_image,
                                                   {in_red, in_green, in_blue}));
      end
      if (out_valid && !out_stall) begin
        if (predicted_tallies.size() == 0) begin
          $error("Result item arrived with no pixel waiting for it.");
          mismatches++;
        end else begin
          want = predicted_tallies.pop_front();
          checked++;
          if (want.overflow) begin
            overflows++;
          end
          if (!want.is_new) begin
            repeats++;
          end
          if (out_is_new !== want.is_new) begin
            $error("is_new: expected %0d, got %0d", want.is_new, out_is_new);
            mismatches++;
          end
          if (out_slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_slot);
            mismatches++;
          end
          if (out_distinct_count !== want.count) begin
            $error("distinct_count: expected %0d, got %0d", want.count, out_distinct_count);
            mismatches++;
          end
          if (out_overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_overflow);
            mismatches++;
          end
        end
      end
    end
    error_count    <= mismatches;
    pending_count  <= predicted_tallies.size();
    checked_count  <= checked;
    overflow_count <= overflows;
    repeat_count   <= repeats;
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the distinct color counter bench: clock, reset, pixel stimulus,
// receiver stalls and the verdict. Depends on dcc_pkg, the core and color_count_checker.
module testbench;

  localparam int RANDOM_ITEMS = 1200;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_start_of_image;
  logic [dcc_pkg::CHAN_W-1:0]      in_red;
  logic [dcc_pkg::CHAN_W-1:0]      in_green;
  logic [dcc_pkg::CHAN_W-1:0]      in_blue;
  logic                            out_valid;
  logic                            out_stall;
  logic                            out_is_new;
  logic [dcc_pkg::SLOT_W-1:0]      out_slot;
  logic [dcc_pkg::COUNT_OUT_W-1:0] out_distinct_count;
  logic                            out_overflow;

  int errors;
  int pending;
  int checked;
  int overflows;
  int repeats;
  int burst_left;
  int sent;

  distinct_color_counter_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_start_of_image  (in_start_of_image),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_new         (out_is_new),
    .out_slot           (out_slot),
    .out_distinct_count (out_distinct_count),
    .out_overflow       (out_overflow)
  );

  color_count_checker checker_inst (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_start_of_image  (in_start_of_image),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_new         (out_is_new),
    .out_slot           (out_slot),
    .out_distinct_count (out_distinct_count),
    .out_overflow       (out_overflow),
    .error_count        (errors),
    .pending_count      (pending),
    .checked_count      (checked),
    .overflow_count     (overflows),
    .repeat_count       (repeats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int stall_run;
    int mode;
    int mode_left;
    out_stall = 1'b0;
    stall_run = 0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(200, 2000);
      end
      mode_left--;
      if (stall_run > 0) begin
        stall_run--;
      end else if (mode == 1 && $urandom_range(0, 1) == 1) begin
        stall_run = $urandom_range(1, 3);
      end else if (mode == 2 && $urandom_range(0, 99) == 0) begin
        stall_run = $urandom_range(10, 60);
      end
      out_stall <= (stall_run > 0);
    end
  end

  task automatic push_pixel(input logic sof, input dcc_pkg::color_t color);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 330) : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_start_of_image <= sof;
    {in_red, in_green, in_blue} <= color;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  initial begin
    dcc_pkg::color_t image_colors [$];
    dcc_pkg::color_t palette [$];
    dcc_pkg::color_t color;
    logic            sof_first;
    int              directed_items;
    int              images;
    int              fresh;
    int              len;
    int              wait_cycles;

    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_start_of_image = 1'b0;
    in_red            = '0;
    in_green          = '0;
    in_blue           = '0;
    burst_left        = 0;
    sent              = 0;
    images            = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The table starts empty after reset, so no start flag is needed here.
    push_pixel(1'b0, 24'h000000);
    push_pixel(1'b0, 24'hffffff);
    push_pixel(1'b0, 24'h000000);
    push_pixel(1'b0, 24'hff0000);
    push_pixel(1'b0, 24'h00ff00);
    push_pixel(1'b0, 24'h0000ff);
    push_pixel(1'b0, 24'hffffff);
    push_pixel(1'b0, 24'h000001);
    push_pixel(1'b0, 24'h800000);
    push_pixel(1'b0, 24'h008000);
    push_pixel(1'b0, 24'h000080);
    push_pixel(1'b0, 24'h0000ff);
    push_pixel(1'b1, 24'h000000);
    push_pixel(1'b1, 24'h000000);
    push_pixel(1'b0, 24'h000000);
    push_pixel(1'b1, 24'hffffff);
    push_pixel(1'b0, 24'h7f7f7f);
    push_pixel(1'b0, 24'h010101);
    push_pixel(1'b0, 24'hffffff);
    push_pixel(1'b0, 24'h7f7f7e);
    directed_items = sent;

    // Mostly images from small palettes, with some images that overrun the table.
    while (sent - directed_items < RANDOM_ITEMS) begin
      sof_first = ($urandom_range(0, 9) != 0);
      if (images == 0 || (sent - directed_items + 340 <= RANDOM_ITEMS &&
                          $urandom_range(0, 9) == 0)) begin
        image_colors.delete();
        fresh = dcc_pkg::TABLE_ENTRIES + $urandom_range(3, 20);
        for (int k = 0; k < fresh; k++) begin
          color = dcc_pkg::color_t'($urandom);
          push_pixel((k == 0) ? sof_first : 1'b0, color);
          image_colors.push_back(color);
          if ($urandom_range(0, 4) == 0) begin
            push_pixel(1'b0, image_colors[$urandom_range(0, image_colors.size() - 1)]);
          end
        end
        push_pixel(1'b0, image_colors[dcc_pkg::TABLE_ENTRIES - 1]);
        push_pixel(1'b0, image_colors[image_colors.size() - 1]);
      end else begin
        palette.delete();
        palette.push_back(dcc_pkg::color_t'($urandom));
        repeat ($urandom_range(0, 11)) begin
          if ($urandom_range(0, 2) == 0) begin
            palette.push_back(palette[0] ^ (24'd1 << $urandom_range(0, 23)));
          end else begin
            palette.push_back(dcc_pkg::color_t'($urandom));
          end
        end
        len = $urandom_range(1, 40);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            color = dcc_pkg::color_t'($urandom);
          end else begin
            color = palette[$urandom_range(0, palette.size() - 1)];
          end
          push_pixel((k == 0) ? sof_first : ($urandom_range(0, 30) == 0), color);
        end
      end
      images++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (2 * dcc_pkg::TABLE_ENTRIES + 8) @(posedge clk);

    if (pending != 0) begin
      $error("%0d pixels never produced a result item.", pending);
    end
    $display("Checked %0d pixel results: %0d directed pixels, then %0d random images.",
             checked, directed_items, images);
    $display("%0d pixels overflowed a full table and %0d matched a stored color.",
             overflows, repeats);
    if (errors == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
